FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: src/u8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Widths, status codes and the decode result type shared by the decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int REM_W  = 2;
  localparam int STAT_W = 2;

  // Status codes of a result.
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_TRUNC   = 2'd2
  } status_t;

  // Decode result handed from the decode stage to the result register.
  typedef struct packed {
    logic             emit;
    logic [CP_W-1:0]  code_point;
    status_t          status;
  } dec_res_t;

endpackage

FILE: src/u8d_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder channels
// Valid/ready channels for raw bytes and for decoded code points.
// ----------------------------------------------------------------------------
interface u8d_byte_if;
  import u8d_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface u8d_cp_if;
  import u8d_pkg::*;

  logic              valid;
  logic              ready;
  logic [CP_W-1:0]   code_point;
  logic [STAT_W-1:0] status;

  modport source (output valid, output code_point, output status, input ready);
  modport sink   (input valid, input code_point, input status, output ready);
endinterface

FILE: src/u8d_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder input register
// Holds one accepted byte until the decode stage consumes it.
// ----------------------------------------------------------------------------
module u8d_in_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [u8d_pkg::BYTE_W-1:0] in_byte,
  input  logic                       consume,
  output logic                       stage_valid,
  output logic [u8d_pkg::BYTE_W-1:0] stage_byte
);
  import u8d_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;

  // The register can take a new byte when empty or emptied this cycle.
  assign in_ready = !valid_r || consume;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  // Occupancy flag and byte register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

  assign stage_valid = valid_r;
  assign stage_byte  = byte_r;

endmodule

FILE: src/u8d_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder sequence logic
// Keeps the partial code point and the count of continuation bytes due, and
// classifies each byte into at most one result.
// ----------------------------------------------------------------------------
module u8d_decode (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic [u8d_pkg::BYTE_W-1:0] byte_in,
  output u8d_pkg::dec_res_t          res
);
  import u8d_pkg::*;

  logic [CP_W-1:0]  acc_r;
  logic [CP_W-1:0]  acc_nxt;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] rem_nxt;
  logic [CP_W-1:0]  shifted;

  // Six payload bits of a continuation byte shift in at the bottom.
  assign shifted = {acc_r[CP_W-7:0], byte_in[5:0]};

  // Next state and result for the byte at the stage output.
  always_comb begin
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    res.emit       = 1'b0;
    res.code_point = '0;
    res.status     = ST_OK;
    if (rem_r != '0) begin
      if (byte_in[7:6] == 2'b10) begin
        rem_nxt = rem_r - REM_W'(1);
        if (rem_r == REM_W'(1)) begin
          res.emit       = 1'b1;
          res.code_point = shifted;
          acc_nxt        = '0;
        end else begin
          acc_nxt = shifted;
        end
      end else if (byte_in == '0) begin
        // A NUL byte cuts the sequence short and reports what was built.
        res.emit       = 1'b1;
        res.code_point = acc_r;
        res.status     = ST_TRUNC;
        acc_nxt        = '0;
        rem_nxt        = '0;
      end else begin
        res.emit   = 1'b1;
        res.status = ST_INVALID;
        acc_nxt    = '0;
        rem_nxt    = '0;
      end
    end else begin
      case (byte_in) inside
        8'b0???????: begin
          res.emit       = 1'b1;
          res.code_point = CP_W'(byte_in);
        end
        8'b110?????: begin
          acc_nxt = CP_W'(byte_in[4:0]);
          rem_nxt = REM_W'(1);
        end
        8'b1110????: begin
          acc_nxt = CP_W'(byte_in[3:0]);
          rem_nxt = REM_W'(2);
        end
        8'b11110???: begin
          acc_nxt = CP_W'(byte_in[2:0]);
          rem_nxt = REM_W'(3);
        end
        default: begin
          // Stray continuation byte or a lead byte with five or more leading ones.
          res.emit   = 1'b1;
          res.status = ST_INVALID;
          acc_nxt    = '0;
        end
      endcase
    end
  end

  // Sequence state advances only when the byte is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      rem_r <= '0;
    end else if (fire) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

FILE: src/u8d_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder result register
// Holds one decoded result until the downstream side takes it.
// ----------------------------------------------------------------------------
module u8d_out_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  u8d_pkg::dec_res_t          res,
  output logic                       free,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [u8d_pkg::CP_W-1:0]   out_code_point,
  output logic [u8d_pkg::STAT_W-1:0] out_status
);
  import u8d_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [CP_W-1:0]   cp_r;
  logic [STAT_W-1:0] status_r;

  // Free when empty or when the held result transfers this cycle.
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  // Result flag and payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      cp_r     <= res.code_point;
      status_r <= res.status;
    end
  end

  assign out_valid      = valid_r;
  assign out_code_point = cp_r;
  assign out_status     = status_r;

endmodule

FILE: src/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Byte-serial UTF-8 decoder with valid/ready channels on both sides.
// ----------------------------------------------------------------------------
// The decoder takes one byte per cycle and gives zero or one result per byte.
// Each byte is held in an input register, decoded combinationally against
// the running sequence state, and its result is loaded into an output
// register, from which it is offered, once that register is free. A lead
// byte that opens a sequence and inner continuation bytes produce no result.
// Throughput is one byte per cycle; the input stalls only while the output
// register holds a result that the sink does not take.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic            clk,
  input  logic            rst_n,
  u8d_byte_if.sink        in_ch,
  u8d_cp_if.source        out_ch
);
  import u8d_pkg::*;
  `include "assert_macros.svh"

  logic              stage_valid;
  logic [BYTE_W-1:0] stage_byte;
  logic              out_free;
  logic              fire;
  dec_res_t          res;
  logic              out_bad_cp;
  logic              out_stalled;
  logic              drain_only;

  // A staged byte is decoded once the result register has room.
  assign fire = stage_valid && out_free;

  u8d_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_byte     (in_ch.byte_in),
    .consume     (fire),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte)
  );

  u8d_decode u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .byte_in (stage_byte),
    .res     (res)
  );

  u8d_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (fire && res.emit),
    .res            (res),
    .free           (out_free),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_code_point (out_ch.code_point),
    .out_status     (out_ch.status)
  );

  // Conditions watched by the checks below.
  assign out_bad_cp  = out_ch.valid && (out_ch.status == ST_INVALID) &&
                       (out_ch.code_point != '0);
  assign out_stalled = out_ch.valid && !out_ch.ready;
  assign drain_only  = stage_valid && !out_ch.valid && !in_ch.valid;

  // Invalid results carry a zero code point.
  `ASSERT_NEVER(a_invalid_zero, out_bad_cp, "invalid result with nonzero code point")
  // The input side stalls only behind a result the sink is refusing.
  `ASSERT_CLK(a_stall_cause, !in_ch.ready |-> (stage_valid && out_stalled), "spurious input stall")
  // A staged byte with room downstream is consumed in the same cycle.
  `ASSERT_CLK(a_no_bubble, drain_only |=> !stage_valid, "staged byte not consumed")

endmodule
